### src/crp_pkg.sv
// ----------------------------------------------------------------------------
// crp_pkg
// Shared types and constants for the A1 cell reference parser.
// ----------------------------------------------------------------------------
package crp_pkg;

   // field widths
   localparam int CH_W       = 8;
   localparam int ROW_W      = 17;
   localparam int COL_W      = 19;
   localparam int CNT_W      = 3;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 19;
   localparam int RSP_DATA_W = 40;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_NUM_ROWS = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_NUM_COLS = 2'd1;

   // register reset values
   localparam logic [ROW_W-1:0] NUM_ROWS_RST = 17'd999;
   localparam logic [COL_W-1:0] NUM_COLS_RST = 19'd18278;

   // length and count limits
   localparam logic [CNT_W-1:0] MIN_LEN     = 3'd2;
   localparam logic [CNT_W-1:0] MAX_LEN     = 3'd6;
   localparam logic [CNT_W-1:0] MAX_LETTERS = 3'd4;
   localparam logic [CNT_W-1:0] MAX_DIGITS  = 3'd5;
   localparam logic [CNT_W-1:0] CNT_SAT     = 3'd7;

   // character codes
   localparam logic [CH_W-1:0] CH_UPPER_A = 8'h41;
   localparam logic [CH_W-1:0] CH_UPPER_Z = 8'h5A;
   localparam logic [CH_W-1:0] CH_BEFORE_A = 8'h40;
   localparam logic [CH_W-1:0] CH_DIGIT_0 = 8'h30;
   localparam logic [CH_W-1:0] CH_DIGIT_9 = 8'h39;

   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_INVALID = 2'd1,
      ST_RANGE   = 2'd2
   } status_type;

   // one request: a character and its end-of-reference flag
   typedef struct packed {
      logic [CH_W-1:0] ch;
      logic            last_char;
   } item_type;

   // one result
   typedef struct packed {
      logic [COL_W-1:0] col_index;
      logic [ROW_W-1:0] row_index;
      status_type       status;
   } result_type;

endpackage

### src/cell_reference_parser.sv
// ----------------------------------------------------------------------------
// cell_reference_parser
// Parses A1-style cell references one character per request and returns
// status, zero-based row and column on the final character.
//
//   Channel  Dir   Contents
//   req_*    in    tdata = ch[7:0], tlast = last_char
//   rsp_*    out   tdata = status[1:0], row_index[18:2], col_index[37:19]
//   csr_*    in    index 0 = num_rows, index 1 = num_cols
//
// One request per cycle while req_tready is high; a character passes the input
// register and the parser, and a final character's result is registered in
// the output register. Reset is synchronous: counters and flags clear,
// num_rows = 999, num_cols = 18278. A result waiting in the output register
// holds the next final character in the input register, which then stalls
// the request channel; csr writes are always taken.
// ----------------------------------------------------------------------------
module cell_reference_parser (
   input  logic                               clock,
   input  logic                               reset,
   // request channel
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [7:0]                         req_tdata,   // ch[7:0]
   input  logic                               req_tlast,
   // result channel
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [crp_pkg::RSP_DATA_W-1:0]     rsp_tdata,   // status, row_index, col_index
   // configuration
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [crp_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [crp_pkg::CSR_DATA_W-1:0]     csr_data
);

   logic [crp_pkg::ROW_W-1:0] num_rows_ff;
   logic [crp_pkg::COL_W-1:0] num_cols_ff;

   crp_pkg::item_type   req_item;
   crp_pkg::item_type   s1_item;
   crp_pkg::result_type res;
   logic                s1_valid;
   logic                take;
   logic                res_valid;
   logic                out_free;

   // configuration registers
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         num_rows_ff <= crp_pkg::NUM_ROWS_RST;
         num_cols_ff <= crp_pkg::NUM_COLS_RST;
      end else if (csr_valid) begin
         if (csr_index == crp_pkg::CSR_NUM_ROWS) begin
            num_rows_ff <= csr_data[crp_pkg::ROW_W-1:0];
         end
         if (csr_index == crp_pkg::CSR_NUM_COLS) begin
            num_cols_ff <= csr_data[crp_pkg::COL_W-1:0];
         end
      end
   end

   assign req_item.ch        = req_tdata;
   assign req_item.last_char = req_tlast;

   crp_in_stage u_in (
      .clock    (clock),
      .reset    (reset),
      .in_valid (req_tvalid),
      .in_ready (req_tready),
      .in_item  (req_item),
      .take     (take),
      .s1_valid (s1_valid),
      .s1_item  (s1_item)
   );

   crp_parse u_parse (
      .clock     (clock),
      .reset     (reset),
      .s1_valid  (s1_valid),
      .s1_item   (s1_item),
      .out_free  (out_free),
      .num_rows  (num_rows_ff),
      .num_cols  (num_cols_ff),
      .take      (take),
      .res_valid (res_valid),
      .res       (res)
   );

   crp_out_stage u_out (
      .clock     (clock),
      .reset     (reset),
      .res_valid (res_valid),
      .res       (res),
      .out_free  (out_free),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (rsp_tdata)
   );

endmodule

### src/crp_in_stage.sv
// ----------------------------------------------------------------------------
// crp_in_stage
// Input register: holds one accepted request until the parser takes it.
// ----------------------------------------------------------------------------
module crp_in_stage (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  crp_pkg::item_type in_item,
   input  logic              take,
   output logic              s1_valid,
   output crp_pkg::item_type s1_item
);

   logic              valid_ff;
   logic              valid_in;
   crp_pkg::item_type item_ff;

   // room when empty or when the held request leaves this cycle
   assign in_ready = !valid_ff || take;
   assign valid_in = in_ready ? in_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         item_ff <= in_item;
      end
   end

   assign s1_valid = valid_ff;
   assign s1_item  = item_ff;

endmodule

### src/crp_parse.sv
// ----------------------------------------------------------------------------
// crp_parse
// Per-reference state: letter/digit accumulators, counters and error flag.
// Produces the status and zero-based indexes on the final character.
// ----------------------------------------------------------------------------
module crp_parse (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             s1_valid,
   input  crp_pkg::item_type                s1_item,
   input  logic                             out_free,
   input  logic [crp_pkg::ROW_W-1:0]        num_rows,
   input  logic [crp_pkg::COL_W-1:0]        num_cols,
   output logic                             take,
   output logic                             res_valid,
   output crp_pkg::result_type              res
);

   logic [crp_pkg::CNT_W-1:0] char_count_ff,   char_count_in;
   logic [crp_pkg::CNT_W-1:0] letter_count_ff, letter_count_in;
   logic [crp_pkg::CNT_W-1:0] digit_count_ff,  digit_count_in;
   logic                      in_row_part_ff,  in_row_part_in;
   logic                      bad_flag_ff,     bad_flag_in;
   logic [crp_pkg::COL_W-1:0] col_accum_ff,    col_accum_in;
   logic [crp_pkg::ROW_W-1:0] row_accum_ff,    row_accum_in;

   logic [crp_pkg::CH_W-1:0]  ch;
   logic                      is_letter;
   logic                      is_digit;
   logic [crp_pkg::COL_W-1:0] col_x26;
   logic [crp_pkg::ROW_W-1:0] row_x10;
   logic [crp_pkg::CH_W-1:0]  letter_val;
   logic [crp_pkg::CH_W-1:0]  digit_val;
   logic                      invalid;
   logic                      out_range;

   // a request without a result never waits for the output slot
   assign take      = s1_valid && (!s1_item.last_char || out_free);
   assign res_valid = take && s1_item.last_char;

   assign ch         = s1_item.ch;
   assign is_letter  = (ch >= crp_pkg::CH_UPPER_A) && (ch <= crp_pkg::CH_UPPER_Z);
   assign is_digit   = (ch >= crp_pkg::CH_DIGIT_0) && (ch <= crp_pkg::CH_DIGIT_9);
   assign letter_val = ch - crp_pkg::CH_BEFORE_A;
   assign digit_val  = ch - crp_pkg::CH_DIGIT_0;

   // constant multiplies as shift-add
   assign col_x26 = (col_accum_ff << 4) + (col_accum_ff << 3) + (col_accum_ff << 1);
   assign row_x10 = (row_accum_ff << 3) + (row_accum_ff << 1);

   // next-state after this character
   always_comb begin
      char_count_in   = char_count_ff;
      letter_count_in = letter_count_ff;
      digit_count_in  = digit_count_ff;
      in_row_part_in  = in_row_part_ff;
      bad_flag_in     = bad_flag_ff;
      col_accum_in    = col_accum_ff;
      row_accum_in    = row_accum_ff;

      if (char_count_ff < crp_pkg::CNT_SAT) begin
         char_count_in = char_count_ff + 3'd1;
      end

      priority if (is_letter) begin
         if (in_row_part_ff) begin
            bad_flag_in = 1'b1;
         end
         if (letter_count_ff < crp_pkg::MAX_LETTERS) begin
            col_accum_in = col_x26 + crp_pkg::COL_W'(letter_val);
         end
         if (letter_count_ff < crp_pkg::CNT_SAT) begin
            letter_count_in = letter_count_ff + 3'd1;
         end
      end else if (is_digit) begin
         in_row_part_in = 1'b1;
         if (digit_count_ff < crp_pkg::MAX_DIGITS) begin
            row_accum_in = row_x10 + crp_pkg::ROW_W'(digit_val);
         end
         if (digit_count_ff < crp_pkg::CNT_SAT) begin
            digit_count_in = digit_count_ff + 3'd1;
         end
      end else begin
         bad_flag_in = 1'b1;
      end
   end

   // end-of-reference checks
   assign invalid = (char_count_in < crp_pkg::MIN_LEN) ||
                    (char_count_in > crp_pkg::MAX_LEN) ||
                    bad_flag_in ||
                    (letter_count_in == 3'd0) ||
                    (digit_count_in == 3'd0) ||
                    (letter_count_in > crp_pkg::MAX_LETTERS);

   assign out_range = (col_accum_in == '0) || (col_accum_in > num_cols) ||
                      (row_accum_in == '0) || (row_accum_in > num_rows);

   always_comb begin
      res.row_index = '0;
      res.col_index = '0;
      priority if (invalid) begin
         res.status = crp_pkg::ST_INVALID;
      end else if (out_range) begin
         res.status = crp_pkg::ST_RANGE;
      end else begin
         res.status    = crp_pkg::ST_OK;
         res.row_index = row_accum_in - 17'd1;
         res.col_index = col_accum_in - 19'd1;
      end
   end

   // state update; clear after the final character
   always_ff @(posedge clock) begin
      if (reset || (take && s1_item.last_char)) begin
         char_count_ff   <= '0;
         letter_count_ff <= '0;
         digit_count_ff  <= '0;
         in_row_part_ff  <= 1'b0;
         bad_flag_ff     <= 1'b0;
         col_accum_ff    <= '0;
         row_accum_ff    <= '0;
      end else if (take) begin
         char_count_ff   <= char_count_in;
         letter_count_ff <= letter_count_in;
         digit_count_ff  <= digit_count_in;
         in_row_part_ff  <= in_row_part_in;
         bad_flag_ff     <= bad_flag_in;
         col_accum_ff    <= col_accum_in;
         row_accum_ff    <= row_accum_in;
      end
   end

endmodule

### src/crp_out_stage.sv
// ----------------------------------------------------------------------------
// crp_out_stage
// Result register: holds one result until the downstream side takes it.
// ----------------------------------------------------------------------------
module crp_out_stage (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               res_valid,
   input  crp_pkg::result_type                res,
   output logic                               out_free,
   output logic                               out_valid,
   input  logic                               out_ready,
   output logic [crp_pkg::RSP_DATA_W-1:0]     out_data
);

   logic                valid_ff;
   logic                valid_in;
   crp_pkg::result_type res_ff;

   assign out_free = !valid_ff || out_ready;
   assign valid_in = out_free ? res_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_free && res_valid) begin
         res_ff <= res;
      end
   end

   assign out_valid = valid_ff;
   // status, row, column from bit 0 up; zero fill to whole bytes
   assign out_data  = {2'b00, res_ff.col_index, res_ff.row_index, res_ff.status};

endmodule

### tb/cell_reference_parser_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cell_reference_parser_tb
// Streams A1 cell references into the parser one character per request and
// checks every returned status, row and column against a local parser model.
// Limits are reprogrammed between phases (reset values, maximum, minimum,
// random, zero, masked) while both stream sides idle at varying rates.
// ----------------------------------------------------------------------------
module cell_reference_parser_tb;

   localparam int STALL_LIMIT = 2000;
   localparam int SHOWN_FAILS = 10;
   // register indexes with no register behind them
   localparam logic [crp_pkg::CSR_IDX_W-1:0] CSR_SPARE_A = 2'd2;
   localparam logic [crp_pkg::CSR_IDX_W-1:0] CSR_SPARE_B = 2'd3;

   logic                           clock = 1'b0;
   logic                           reset = 1'b1;
   logic                           req_tvalid = 1'b0;
   logic                           req_tready;
   logic [crp_pkg::CH_W-1:0]       req_tdata = '0;   // ch[7:0]
   logic                           req_tlast = 1'b0;
   logic                           rsp_tvalid;
   logic                           rsp_tready = 1'b0;
   logic [crp_pkg::RSP_DATA_W-1:0] rsp_tdata;  // status[1:0], row_index[18:2], col_index[37:19]
   logic                           csr_valid = 1'b0;
   logic                           csr_ready;
   logic [crp_pkg::CSR_IDX_W-1:0]  csr_index = '0;
   logic [crp_pkg::CSR_DATA_W-1:0] csr_data = '0;

   // characters waiting to be sent and parse results still due
   crp_pkg::item_type   ref_chars[$];
   crp_pkg::result_type cell_results_due[$];

   int send_idle_pct = 9;
   int recv_idle_pct = 60;
   int fail_count = 0;
   int idle_cycles = 0;

   // local copy of the sheet limits and of the parser state
   logic [crp_pkg::ROW_W-1:0] sheet_rows = crp_pkg::NUM_ROWS_RST;
   logic [crp_pkg::COL_W-1:0] sheet_cols = crp_pkg::NUM_COLS_RST;
   logic [crp_pkg::CNT_W-1:0] n_chars = '0;
   logic [crp_pkg::CNT_W-1:0] n_letters = '0;
   logic [crp_pkg::CNT_W-1:0] n_digits = '0;
   logic                      seen_digit = 1'b0;
   logic                      bad_char = 1'b0;
   logic [crp_pkg::COL_W-1:0] col_acc = '0;
   logic [crp_pkg::ROW_W-1:0] row_acc = '0;

   always #1 clock = ~clock;

   cell_reference_parser u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   task automatic log_failure(input string msg);
      fail_count++;
      if (fail_count <= SHOWN_FAILS) begin
         $display("%0t: %s", $realtime, msg);
      end
   endtask

   // advance the parser by one character; a final character yields a result
   task automatic parse_char(input logic [crp_pkg::CH_W-1:0] c, input logic fin);
      crp_pkg::result_type res;
      if (n_chars != crp_pkg::CNT_SAT) n_chars++;
      if (c >= crp_pkg::CH_UPPER_A && c <= crp_pkg::CH_UPPER_Z) begin
         if (seen_digit) bad_char = 1'b1;
         // bijective base 26: A counts as one
         if (n_letters < crp_pkg::MAX_LETTERS) begin
            col_acc = crp_pkg::COL_W'(col_acc * 26 + (c - crp_pkg::CH_BEFORE_A));
         end
         if (n_letters != crp_pkg::CNT_SAT) n_letters++;
      end else if (c >= crp_pkg::CH_DIGIT_0 && c <= crp_pkg::CH_DIGIT_9) begin
         seen_digit = 1'b1;
         if (n_digits < crp_pkg::MAX_DIGITS) begin
            row_acc = crp_pkg::ROW_W'(row_acc * 10 + (c - crp_pkg::CH_DIGIT_0));
         end
         if (n_digits != crp_pkg::CNT_SAT) n_digits++;
      end else begin
         bad_char = 1'b1;
      end
      if (fin) begin
         res = '0;
         if (n_chars < crp_pkg::MIN_LEN || n_chars > crp_pkg::MAX_LEN || bad_char ||
             n_letters == 0 || n_digits == 0 || n_letters > crp_pkg::MAX_LETTERS) begin
            res.status = crp_pkg::ST_INVALID;
         end else if (col_acc == 0 || col_acc > sheet_cols ||
                      row_acc == 0 || row_acc > sheet_rows) begin
            res.status = crp_pkg::ST_RANGE;
         end else begin
            res.status    = crp_pkg::ST_OK;
            res.row_index = row_acc - 1'b1;
            res.col_index = col_acc - 1'b1;
         end
         cell_results_due.push_back(res);
         n_chars    = '0;
         n_letters  = '0;
         n_digits   = '0;
         seen_digit = 1'b0;
         bad_char   = 1'b0;
         col_acc    = '0;
         row_acc    = '0;
      end
   endtask

   // request driver: predicts on acceptance, then loads the next character
   always @(posedge clock) begin : req_driver
      crp_pkg::item_type next_char;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) parse_char(req_tdata, req_tlast);
         if (!req_tvalid || req_tready) begin
            if (ref_chars.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
               next_char = ref_chars.pop_front();
               req_tvalid <= 1'b1;
               req_tdata  <= next_char.ch;
               req_tlast  <= next_char.last_char;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // result monitor with random backpressure
   always @(posedge clock) begin : rsp_monitor
      crp_pkg::result_type got;
      crp_pkg::result_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
         if (rsp_tvalid && rsp_tready) begin
            got = crp_pkg::result_type'(rsp_tdata[37:0]);
            if (cell_results_due.size() == 0) begin
               log_failure($sformatf("unexpected result, data %h", rsp_tdata));
            end else begin
               want = cell_results_due.pop_front();
               if (got.status !== want.status || got.row_index !== want.row_index ||
                   got.col_index !== want.col_index || rsp_tdata[39:38] !== 2'b00) begin
                  log_failure($sformatf(
                     "expected status %0d row %0d col %0d, got status %0d row %0d col %0d pad %b",
                     want.status, want.row_index, want.col_index,
                     got.status, got.row_index, got.col_index, rsp_tdata[39:38]));
               end
            end
         end
      end
   end

   // stall watchdog: any handshake restarts the count
   always @(posedge clock) begin : watchdog
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles == STALL_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   task automatic write_csr(input logic [crp_pkg::CSR_IDX_W-1:0] idx, input int unsigned val);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= crp_pkg::CSR_DATA_W'(val);
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         crp_pkg::CSR_NUM_ROWS: sheet_rows = crp_pkg::ROW_W'(val);
         crp_pkg::CSR_NUM_COLS: sheet_cols = crp_pkg::COL_W'(val);
         default: ;
      endcase
   endtask

   task automatic add_text(input string s);
      for (int i = 0; i < s.len(); i++) begin
         ref_chars.push_back(crp_pkg::item_type'{ch: s[i], last_char: (i == s.len() - 1)});
      end
   endtask

   // mostly well-formed references with random content, the rest noise
   task automatic add_random_ref();
      logic [crp_pkg::CH_W-1:0] c;
      int n_let;
      int n_dig;
      int len;
      if ($urandom_range(0, 99) < 70) begin
         n_let = ($urandom_range(0, 9) == 0) ? 5 : $urandom_range(1, 4);
         n_dig = (n_let == 5) ? 1 : $urandom_range(1, 6 - n_let);
         len = n_let + n_dig;
         for (int i = 0; i < len; i++) begin
            if (i < n_let) begin
               c = crp_pkg::CH_W'(crp_pkg::CH_UPPER_A + $urandom_range(0, 25));
            end else begin
               c = crp_pkg::CH_W'(crp_pkg::CH_DIGIT_0 + $urandom_range(0, 9));
            end
            ref_chars.push_back(crp_pkg::item_type'{ch: c, last_char: (i == len - 1)});
         end
      end else begin
         len = $urandom_range(1, 8);
         for (int i = 0; i < len; i++) begin
            case ($urandom_range(0, 4))
               0: c = crp_pkg::CH_W'($urandom_range(0, 255));
               1: c = crp_pkg::CH_W'(crp_pkg::CH_UPPER_A + $urandom_range(0, 25));
               2: c = crp_pkg::CH_W'(crp_pkg::CH_DIGIT_0 + $urandom_range(0, 9));
               // lowercase
               3: c = crp_pkg::CH_W'(crp_pkg::CH_UPPER_A + 8'd32 + $urandom_range(0, 25));
               default: begin
                  // bytes just outside the letter and digit ranges
                  case ($urandom_range(0, 3))
                     0: c = crp_pkg::CH_BEFORE_A;
                     1: c = crp_pkg::CH_UPPER_Z + 1'b1;
                     2: c = crp_pkg::CH_DIGIT_0 - 1'b1;
                     default: c = crp_pkg::CH_DIGIT_9 + 1'b1;
                  endcase
               end
            endcase
            ref_chars.push_back(crp_pkg::item_type'{ch: c, last_char: (i == len - 1)});
         end
      end
   endtask

   // wait until everything sent has been answered, then let the pipe settle
   task automatic drain();
      while (ref_chars.size() != 0 || req_tvalid || cell_results_due.size() != 0) begin
         @(negedge clock);
      end
      repeat (4) @(negedge clock);
   endtask

   task automatic run_random(input int n_chars_min);
      @(negedge clock);
      while (ref_chars.size() < n_chars_min) add_random_ref();
      drain();
   endtask

   initial begin : stimulus
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed references at reset limits
      add_text("A1");        // smallest valid
      add_text("ZZZZ9");     // widest column, beyond the default limit
      add_text("AAAAA1");    // too many letters
      add_text("B0");        // row zero
      add_text("1C");        // letter after digit
      add_text("AB");        // no row
      add_text("99");        // no column
      add_text("A123456");   // too long, digits past five
      add_text("Z");         // too short
      drain();

      write_csr(crp_pkg::CSR_NUM_ROWS, 99999);
      write_csr(crp_pkg::CSR_NUM_COLS, 475254);
      run_random(300);

      send_idle_pct = 60;
      recv_idle_pct = 9;
      write_csr(crp_pkg::CSR_NUM_ROWS, 1);
      write_csr(crp_pkg::CSR_NUM_COLS, 1);
      run_random(150);
      write_csr(crp_pkg::CSR_NUM_ROWS, $urandom_range(1, 99999));
      write_csr(crp_pkg::CSR_NUM_COLS, $urandom_range(1, 475254));
      run_random(150);

      // zero limits; spare indexes must leave the limits alone
      send_idle_pct = 0;
      recv_idle_pct = 0;
      write_csr(crp_pkg::CSR_NUM_ROWS, 0);
      write_csr(crp_pkg::CSR_NUM_COLS, 0);
      write_csr(CSR_SPARE_A, $urandom_range(1, 475254));
      write_csr(CSR_SPARE_B, $urandom_range(1, 475254));
      run_random(60);

      // row write with bits above the register width; column limit at ZZ
      write_csr(crp_pkg::CSR_NUM_ROWS, 32'h0007FFFF);
      write_csr(crp_pkg::CSR_NUM_COLS, 702);
      run_random(240);

      repeat (10) @(negedge clock);
      if (cell_results_due.size() != 0) begin
         log_failure($sformatf("%0d results never arrived", cell_results_due.size()));
      end
      if (fail_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
